/* sv/bsp_pkg.sv */
// ----------------------------------------------------------------------------
// Beacon scan parser package
// Shared types and constants of the scan-reply line parser.
// ----------------------------------------------------------------------------
package bsp_pkg;

	localparam int LINE_DEPTH_DEF = 128;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 64;

	typedef enum logic [2:0] {
		KIND_BEACON = 3'd0,
		KIND_DEVICE = 3'd1,
		KIND_START  = 3'd2,
		KIND_END    = 3'd3,
		KIND_OTHER  = 3'd4
	} line_kind_t;

	typedef struct packed {
		logic [31:0] company_prefix;
		logic [63:0] uuid_high;
		logic [63:0] uuid_low;
	} cfg_t;

	typedef struct packed {
		line_kind_t         line_kind;
		logic [15:0]        major_id;
		logic [15:0]        minor_id;
		logic signed [7:0]  tx_power;
		logic signed [15:0] rssi_dbm;
		logic [15:0]        devices_seen;
		logic [15:0]        beacons_seen;
	} res_t;

endpackage

/* sv/bsp_regs.sv */
// ----------------------------------------------------------------------------
// Beacon scan parser configuration registers
// APB-style register file holding the company prefix and the beacon UUID.
// ----------------------------------------------------------------------------
module bsp_regs
	import bsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	localparam logic [1:0] RegCompany  = 2'd0;
	localparam logic [1:0] RegUuidHigh = 2'd1;
	localparam logic [1:0] RegUuidLow  = 2'd2;

	localparam logic [31:0] CompanyReset  = 32'h4C00_0215;
	localparam logic [63:0] UuidHighReset = 64'h7427_8BDA_B644_4520;
	localparam logic [63:0] UuidLowReset  = 64'h8F0C_720E_AF05_9935;

	logic [1:0] reg_sel;
	logic       wr_en;
	cfg_t       cfg_q;

	assign reg_sel = paddr[ADDR_W-1:3];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.company_prefix <= CompanyReset;
			cfg_q.uuid_high      <= UuidHighReset;
			cfg_q.uuid_low       <= UuidLowReset;
		end else if (wr_en) begin
			unique case (reg_sel)
				RegCompany:  cfg_q.company_prefix <= pwdata[31:0];
				RegUuidHigh: cfg_q.uuid_high      <= pwdata;
				RegUuidLow:  cfg_q.uuid_low       <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			RegCompany:  prdata = {32'd0, cfg_q.company_prefix};
			RegUuidHigh: prdata = cfg_q.uuid_high;
			RegUuidLow:  prdata = cfg_q.uuid_low;
			default:     prdata = '0;
		endcase
	end

endmodule

/* sv/bsp_front.sv */
// ----------------------------------------------------------------------------
// Beacon scan parser front end
// Accepts received bytes, drops line feeds and overlong line tails, and tags
// each remaining byte with its line position.
// ----------------------------------------------------------------------------
module bsp_front
	import bsp_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF,
	localparam int PosW = $clog2(LINE_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      rx_byte,
	output logic            tok_valid,
	input  logic            tok_ready,
	output logic            tok_eol,
	output logic [7:0]      tok_data,
	output logic [PosW-1:0] tok_pos
);

	localparam logic [7:0]      CharLf  = 8'h0A;
	localparam logic [7:0]      CharCr  = 8'h0D;
	localparam logic [PosW-1:0] PosLast = PosW'(LINE_DEPTH - 1);

	logic [PosW-1:0] pos_q;
	logic            is_lf;
	logic            is_cr;
	logic            room;
	logic            accept;

	assign is_lf  = rx_byte == CharLf;
	assign is_cr  = rx_byte == CharCr;
	assign room   = pos_q != PosLast;
	assign accept = in_valid && in_ready;

	// Every byte waits for queue space, even one that is dropped.
	assign in_ready  = tok_ready;
	assign tok_valid = in_valid && (is_cr || (!is_lf && room));
	assign tok_eol   = is_cr;
	assign tok_data  = rx_byte;
	assign tok_pos   = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (accept) begin
			if (is_cr) begin
				pos_q <= '0;
			end else if (!is_lf && room) begin
				pos_q <= pos_q + PosW'(1);
			end
		end
	end

endmodule

/* sv/bsp_queue.sv */
// ----------------------------------------------------------------------------
// Beacon scan parser token queue
// Four-entry register queue between the front end and the back end.
// ----------------------------------------------------------------------------
module bsp_queue #(
	parameter int WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int Depth = 4;
	localparam int PtrW  = $clog2(Depth);

	logic [WIDTH-1:0] mem_q [Depth];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [PtrW:0]    count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != (PtrW + 1)'(Depth);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PtrW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (PtrW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (PtrW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* sv/bsp_back.sv */
// ----------------------------------------------------------------------------
// Beacon scan parser back end
// Checks each tagged byte against its position, accumulates the beacon fields
// and turns every line end into one registered result.
// ----------------------------------------------------------------------------
module bsp_back
	import bsp_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF,
	localparam int PosW = $clog2(LINE_DEPTH)
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            tok_valid,
	output logic            tok_ready,
	input  logic            tok_eol,
	input  logic [7:0]      tok_data,
	input  logic [PosW-1:0] tok_pos,
	output logic            res_valid,
	input  logic            res_ready,
	output res_t            res
);

	typedef enum logic [1:0] {
		PH_BLANK,
		PH_POS,
		PH_NEG,
		PH_DONE
	} rssi_phase_t;

	localparam logic [8:0] PosCompany    = 9'd8;
	localparam logic [8:0] PosCompanyEnd = 9'd16;
	localparam logic [8:0] PosUuid       = 9'd17;
	localparam logic [8:0] PosUuidLow    = 9'd33;
	localparam logic [8:0] PosUuidEnd    = 9'd49;
	localparam logic [8:0] PosMajor      = 9'd50;
	localparam logic [8:0] PosMinor      = 9'd54;
	localparam logic [8:0] PosPower      = 9'd58;
	localparam logic [8:0] PosPowerEnd   = 9'd60;
	localparam logic [8:0] PosRssi       = 9'd74;

	localparam logic [63:0] PfxDisc  = "OK+DISC:";
	localparam logic [63:0] PfxStart = "OK+DISIS";
	localparam logic [63:0] PfxEnd   = "OK+DISCE";

	localparam int FlagDisc  = 0;
	localparam int FlagStart = 1;
	localparam int FlagEnd   = 2;
	localparam int FlagId    = 3;

	localparam int StopMajor = 0;
	localparam int StopMinor = 1;
	localparam int StopPower = 2;

	localparam logic [7:0] CharZero  = "0";
	localparam logic [7:0] CharNine  = "9";
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharVt    = 8'h0B;
	localparam logic [7:0] CharFf    = 8'h0C;
	localparam logic [7:0] CharPlus  = "+";
	localparam logic [7:0] CharMinus = "-";

	localparam logic [18:0] RssiCap = 19'd32768;

	function automatic logic [7:0] pfx_char(input logic [63:0] pfx, input logic [2:0] idx);
		pfx_char = 8'(pfx >> {~idx, 3'b000});
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		hex_char = (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h37 + 8'(nib);
	endfunction

	// Bit 4 of the result marks a character that is not a hex digit.
	function automatic logic [4:0] hex_val(input logic [7:0] c);
		if (c >= "0" && c <= "9") begin
			hex_val = {1'b0, 4'(c - 8'h30)};
		end else if (c >= "A" && c <= "F") begin
			hex_val = {1'b0, 4'(c - 8'h37)};
		end else if (c >= "a" && c <= "f") begin
			hex_val = {1'b0, 4'(c - 8'h57)};
		end else begin
			hex_val = 5'h10;
		end
	endfunction

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		sat_inc = (v != 16'hFFFF) ? v + 16'd1 : v;
	endfunction

	logic [3:0]  flags_q, flags_d;
	logic [15:0] major_q, major_d;
	logic [15:0] minor_q, minor_d;
	logic [7:0]  power_q, power_d;
	logic [2:0]  stop_q, stop_d;
	logic [15:0] rssi_q, rssi_d;
	rssi_phase_t phase_q, phase_d;
	logic [15:0] dev_q, dev_d;
	logic [15:0] bea_q, bea_d;
	logic        res_valid_q;
	res_t        res_q, res_d;

	logic [8:0]  p;
	logic [3:0]  company_nib;
	logic [3:0]  uuid_k;
	logic [3:0]  uuid_nib;
	logic [4:0]  hv;
	logic        is_digit;
	logic [18:0] rssi_sum;
	logic        full_prefix;
	logic        pop;

	assign p         = 9'(tok_pos);
	assign tok_ready = !tok_eol || !res_valid_q || res_ready;
	assign pop       = tok_valid && tok_ready;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Positions of both UUID halves differ by sixteen, so one digit index serves both.
	assign company_nib = 4'(cfg.company_prefix >> {~p[2:0], 2'b00});
	assign uuid_k      = 4'(p - PosUuid);
	assign uuid_nib    = (p < PosUuidLow) ? 4'(cfg.uuid_high >> {~uuid_k, 2'b00})
	                                      : 4'(cfg.uuid_low >> {~uuid_k, 2'b00});
	assign hv          = hex_val(tok_data);
	assign is_digit    = tok_data >= CharZero && tok_data <= CharNine;
	assign rssi_sum    = ({3'd0, rssi_q} << 3) + ({3'd0, rssi_q} << 1)
	                   + 19'(tok_data - CharZero);
	assign full_prefix = p >= PosCompany;

	// Per-byte update of the line state.
	always_comb begin
		flags_d = flags_q;
		major_d = major_q;
		minor_d = minor_q;
		power_d = power_q;
		stop_d  = stop_q;
		rssi_d  = rssi_q;
		phase_d = phase_q;
		if (p < PosCompany) begin
			if (tok_data != pfx_char(PfxDisc, p[2:0])) flags_d[FlagDisc] = 1'b1;
			if (tok_data != pfx_char(PfxStart, p[2:0])) flags_d[FlagStart] = 1'b1;
			if (tok_data != pfx_char(PfxEnd, p[2:0])) flags_d[FlagEnd] = 1'b1;
		end else if (p < PosCompanyEnd) begin
			if (tok_data != hex_char(company_nib)) flags_d[FlagId] = 1'b1;
		end else if (p >= PosUuid && p < PosUuidEnd) begin
			if (tok_data != hex_char(uuid_nib)) flags_d[FlagId] = 1'b1;
		end else if (p >= PosMajor && p < PosMinor) begin
			if (!stop_q[StopMajor]) begin
				if (hv[4]) stop_d[StopMajor] = 1'b1;
				else major_d = {major_q[11:0], hv[3:0]};
			end
		end else if (p >= PosMinor && p < PosPower) begin
			if (!stop_q[StopMinor]) begin
				if (hv[4]) stop_d[StopMinor] = 1'b1;
				else minor_d = {minor_q[11:0], hv[3:0]};
			end
		end else if (p >= PosPower && p < PosPowerEnd) begin
			if (!stop_q[StopPower]) begin
				if (hv[4]) stop_d[StopPower] = 1'b1;
				else power_d = {power_q[3:0], hv[3:0]};
			end
		end else if (p >= PosRssi && phase_q != PH_DONE) begin
			if (is_digit) begin
				rssi_d = (rssi_sum > RssiCap) ? 16'(RssiCap) : 16'(rssi_sum);
				if (phase_q == PH_BLANK) phase_d = PH_POS;
			end else if (phase_q == PH_BLANK) begin
				case (tok_data) inside
					CharSpace, CharTab, CharVt, CharFf: phase_d = PH_BLANK;
					CharPlus:  phase_d = PH_POS;
					CharMinus: phase_d = PH_NEG;
					default:   phase_d = PH_DONE;
				endcase
			end else begin
				phase_d = PH_DONE;
			end
		end
	end

	// Line-end classification and count update.
	always_comb begin
		dev_d = dev_q;
		bea_d = bea_q;
		res_d = '0;
		if (full_prefix && !flags_q[FlagDisc]) begin
			dev_d = sat_inc(dev_q);
			if (p >= PosUuidEnd && !flags_q[FlagId]) begin
				bea_d           = sat_inc(bea_q);
				res_d.line_kind = KIND_BEACON;
				res_d.major_id  = major_q;
				res_d.minor_id  = minor_q;
				res_d.tx_power  = power_q;
				if (phase_q == PH_NEG) res_d.rssi_dbm = 16'(16'd0 - rssi_q);
				else if (rssi_q[15]) res_d.rssi_dbm = 16'h7FFF;
				else res_d.rssi_dbm = rssi_q;
			end else begin
				res_d.line_kind = KIND_DEVICE;
			end
		end else if (full_prefix && !flags_q[FlagStart]) begin
			dev_d           = '0;
			bea_d           = '0;
			res_d.line_kind = KIND_START;
		end else if (full_prefix && !flags_q[FlagEnd]) begin
			res_d.line_kind = KIND_END;
		end else begin
			res_d.line_kind = KIND_OTHER;
		end
		res_d.devices_seen = dev_d;
		res_d.beacons_seen = bea_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q     <= '0;
			major_q     <= '0;
			minor_q     <= '0;
			power_q     <= '0;
			stop_q      <= '0;
			rssi_q      <= '0;
			phase_q     <= PH_BLANK;
			dev_q       <= '0;
			bea_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && tok_eol) begin
				flags_q     <= '0;
				major_q     <= '0;
				minor_q     <= '0;
				power_q     <= '0;
				stop_q      <= '0;
				rssi_q      <= '0;
				phase_q     <= PH_BLANK;
				dev_q       <= dev_d;
				bea_q       <= bea_d;
				res_valid_q <= 1'b1;
			end else begin
				if (pop) begin
					flags_q <= flags_d;
					major_q <= major_d;
					minor_q <= minor_d;
					power_q <= power_d;
					stop_q  <= stop_d;
					rssi_q  <= rssi_d;
					phase_q <= phase_d;
				end
				if (res_ready) begin
					res_valid_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && tok_eol) begin
			res_q <= res_d;
		end
	end

endmodule

/* sv/ble_beacon_scan_line_parser.sv */
// ----------------------------------------------------------------------------
// Beacon scan-reply line parser
// Parses the serial scan reply of a Bluetooth module into one result per line.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock cycle on the input channel
// while the token queue has room, independent of line content; line feeds and
// bytes past the line buffer depth are taken and discarded. Each carriage
// return produces one result transaction: the accepted carriage return is
// written into the four-entry token queue between the front end and the back
// end, and the back end then moves its result into the output register. The
// front end stalls only when that queue is full, which happens only while a
// finished result waits on the output and further line ends follow. The
// configuration registers sit at byte addresses 0, 8 and 16 and read back as
// written; there is no clearing pass after reset.
module ble_beacon_scan_line_parser
	import bsp_pkg::*;
#(
	parameter int LINE_DEPTH = LINE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]  prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         line_kind,
	output logic [15:0]        major_id,
	output logic [15:0]        minor_id,
	output logic signed [7:0]  tx_power,
	output logic signed [15:0] rssi_dbm,
	output logic [15:0]        devices_seen,
	output logic [15:0]        beacons_seen
);

	localparam int PosW = $clog2(LINE_DEPTH);
	localparam int TokW = 1 + 8 + PosW;

	cfg_t            cfg;
	res_t            res;
	logic            f_valid;
	logic            f_ready;
	logic            f_eol;
	logic [7:0]      f_data;
	logic [PosW-1:0] f_pos;
	logic            b_valid;
	logic            b_ready;
	logic            b_eol;
	logic [7:0]      b_data;
	logic [PosW-1:0] b_pos;
	logic [TokW-1:0] b_tok;

	bsp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bsp_front #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_byte   (rx_byte),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok_eol   (f_eol),
		.tok_data  (f_data),
		.tok_pos   (f_pos)
	);

	bsp_queue #(
		.WIDTH (TokW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_data  ({f_eol, f_data, f_pos}),
		.rd_valid (b_valid),
		.rd_ready (b_ready),
		.rd_data  (b_tok)
	);

	assign b_eol  = b_tok[TokW-1];
	assign b_data = b_tok[PosW +: 8];
	assign b_pos  = b_tok[PosW-1:0];

	bsp_back #(
		.LINE_DEPTH (LINE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.tok_valid (b_valid),
		.tok_ready (b_ready),
		.tok_eol   (b_eol),
		.tok_data  (b_data),
		.tok_pos   (b_pos),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign line_kind    = res.line_kind;
	assign major_id     = res.major_id;
	assign minor_id     = res.minor_id;
	assign tx_power     = res.tx_power;
	assign rssi_dbm     = res.rssi_dbm;
	assign devices_seen = res.devices_seen;
	assign beacons_seen = res.beacons_seen;

	// Beacon fields are zero on every line that is not a matching beacon.
	a_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_kind != KIND_BEACON |->
			major_id == 16'd0 && minor_id == 16'd0 && tx_power == 8'sd0
			&& rssi_dbm == 16'sd0)
		else $error("beacon fields set on a non-beacon line");

	// Every beacon is also a device, so the beacon count never leads.
	a_count_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> beacons_seen <= devices_seen)
		else $error("beacon count exceeds device count");

	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_kind == KIND_START |->
			devices_seen == 16'd0 && beacons_seen == 16'd0)
		else $error("scan start did not clear the counts");

	a_beacon_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_kind == KIND_BEACON |->
			devices_seen != 16'd0 && beacons_seen != 16'd0)
		else $error("beacon reported with a zero count");

endmodule

/* tb/scan_reply_sb_pkg.sv */
// ----------------------------------------------------------------------------
// Scan-reply scoreboard package
// Line-by-line prediction of the scan-reply parser and the comparison of
// every result transaction against the oldest pending line end.
// ----------------------------------------------------------------------------
package scan_reply_sb_pkg;
	import bsp_pkg::*;

	localparam int REG_COMPANY = 0;
	localparam int REG_UUID_HI = 1;
	localparam int REG_UUID_LO = 2;

	localparam logic [7:0] CHAR_LF = 8'h0A;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	localparam int POS_COMPANY   = 8;
	localparam int POS_UUID_HI   = 17;
	localparam int POS_UUID_LO   = 33;
	localparam int POS_UUID_END  = 49;
	localparam int POS_MAJOR     = 50;
	localparam int POS_MINOR     = 54;
	localparam int POS_POWER     = 58;
	localparam int POS_POWER_END = 60;
	localparam int POS_RSSI      = 74;
	localparam int RSSI_CAP      = 32768;

	localparam logic [63:0] TAG_DISC  = "OK+DISC:";
	localparam logic [63:0] TAG_START = "OK+DISIS";
	localparam logic [63:0] TAG_END   = "OK+DISCE";

	typedef enum logic [1:0] {
		RSSI_BLANKS,
		RSSI_POS,
		RSSI_NEG,
		RSSI_DONE
	} rssi_phase_t;

	// Bit 4 set means the character is not a hex digit.
	function automatic logic [4:0] hex_value(logic [7:0] c);
		if (c >= "0" && c <= "9") return {1'b0, 4'(c - 8'h30)};
		if (c >= "A" && c <= "F") return {1'b0, 4'(c - 8'h37)};
		if (c >= "a" && c <= "f") return {1'b0, 4'(c - 8'h57)};
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + 8'(n) : 8'h37 + 8'(n);
	endfunction

	class scan_reply_scoreboard;
		logic [31:0] company;
		logic [63:0] uuid_hi;
		logic [63:0] uuid_lo;
		int          failures;
		res_t        expected_lines[$];

		int          line_pos;
		logic [3:0]  mismatch;
		logic [15:0] major_acc;
		logic [15:0] minor_acc;
		logic [7:0]  power_acc;
		logic [2:0]  hex_stopped;
		int          rssi_mag;
		rssi_phase_t rssi_phase;
		logic [15:0] device_count;
		logic [15:0] beacon_count;

		function new();
			company      = 32'h4C00_0215;
			uuid_hi      = 64'h7427_8BDA_B644_4520;
			uuid_lo      = 64'h8F0C_720E_AF05_9935;
			failures     = 0;
			device_count = '0;
			beacon_count = '0;
			clear_line();
		endfunction

		function void clear_line();
			line_pos    = 0;
			mismatch    = '0;
			major_acc   = '0;
			minor_acc   = '0;
			power_acc   = '0;
			hex_stopped = '0;
			rssi_mag    = 0;
			rssi_phase  = RSSI_BLANKS;
		endfunction

		function void write_register(int idx, logic [63:0] value);
			case (idx)
				REG_COMPANY: company = value[31:0];
				REG_UUID_HI: uuid_hi = value;
				REG_UUID_LO: uuid_lo = value;
				default: ;
			endcase
		endfunction

		function void store_char(logic [7:0] c, int p);
			logic [4:0] hv;
			logic [3:0] nib;
			int         m;
			hv = hex_value(c);
			if (p < POS_COMPANY) begin
				if (c != TAG_DISC[8*(7-p) +: 8]) mismatch[0] = 1'b1;
				if (c != TAG_START[8*(7-p) +: 8]) mismatch[1] = 1'b1;
				if (c != TAG_END[8*(7-p) +: 8]) mismatch[2] = 1'b1;
			end else if (p < POS_COMPANY + 8) begin
				nib = company[4*(7 - (p - POS_COMPANY)) +: 4];
				if (c != hex_char(nib)) mismatch[3] = 1'b1;
			end else if (p >= POS_UUID_HI && p < POS_UUID_LO) begin
				nib = uuid_hi[4*(15 - (p - POS_UUID_HI)) +: 4];
				if (c != hex_char(nib)) mismatch[3] = 1'b1;
			end else if (p >= POS_UUID_LO && p < POS_UUID_END) begin
				nib = uuid_lo[4*(15 - (p - POS_UUID_LO)) +: 4];
				if (c != hex_char(nib)) mismatch[3] = 1'b1;
			end else if (p >= POS_MAJOR && p < POS_MINOR) begin
				if (hv[4]) hex_stopped[0] = 1'b1;
				else if (!hex_stopped[0]) major_acc = {major_acc[11:0], hv[3:0]};
			end else if (p >= POS_MINOR && p < POS_POWER) begin
				if (hv[4]) hex_stopped[1] = 1'b1;
				else if (!hex_stopped[1]) minor_acc = {minor_acc[11:0], hv[3:0]};
			end else if (p >= POS_POWER && p < POS_POWER_END) begin
				if (hv[4]) hex_stopped[2] = 1'b1;
				else if (!hex_stopped[2]) power_acc = {power_acc[3:0], hv[3:0]};
			end else if (p >= POS_RSSI && rssi_phase != RSSI_DONE) begin
				if (c >= "0" && c <= "9") begin
					m = rssi_mag * 10 + int'(c - 8'h30);
					rssi_mag = (m > RSSI_CAP) ? RSSI_CAP : m;
					if (rssi_phase == RSSI_BLANKS) rssi_phase = RSSI_POS;
				end else if (rssi_phase == RSSI_BLANKS) begin
					if (c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C) begin
						rssi_phase = RSSI_BLANKS;
					end else if (c == "+") begin
						rssi_phase = RSSI_POS;
					end else if (c == "-") begin
						rssi_phase = RSSI_NEG;
					end else begin
						rssi_phase = RSSI_DONE;
					end
				end else begin
					rssi_phase = RSSI_DONE;
				end
			end
		endfunction

		// Called for every byte the block accepts; a carriage return closes the
		// line and queues the result the block must produce for it.
		function void take_byte(logic [7:0] c);
			res_t r;
			bit   full_tag;
			if (c == CHAR_LF) return;
			if (c != CHAR_CR) begin
				if (line_pos < LINE_DEPTH_DEF - 1) begin
					store_char(c, line_pos);
					line_pos++;
				end
				return;
			end
			r = '0;
			full_tag = (line_pos >= 8);
			if (full_tag && !mismatch[0]) begin
				if (device_count != 16'hFFFF) device_count++;
				if (line_pos >= POS_UUID_END && !mismatch[3]) begin
					if (beacon_count != 16'hFFFF) beacon_count++;
					r.line_kind = KIND_BEACON;
					r.major_id  = major_acc;
					r.minor_id  = minor_acc;
					r.tx_power  = power_acc;
					if (rssi_phase == RSSI_NEG) r.rssi_dbm = 16'(-rssi_mag);
					else r.rssi_dbm = 16'((rssi_mag > 32767) ? 32767 : rssi_mag);
				end else begin
					r.line_kind = KIND_DEVICE;
				end
			end else if (full_tag && !mismatch[1]) begin
				device_count = '0;
				beacon_count = '0;
				r.line_kind  = KIND_START;
			end else if (full_tag && !mismatch[2]) begin
				r.line_kind = KIND_END;
			end else begin
				r.line_kind = KIND_OTHER;
			end
			r.devices_seen = device_count;
			r.beacons_seen = beacon_count;
			expected_lines.push_back(r);
			clear_line();
		endfunction

		function void compare_field(string name, logic signed [31:0] want,
			logic signed [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_lines.size() == 0) begin
				$error("result transaction with no line end pending (line_kind %0d)",
					got.line_kind);
				failures++;
				return;
			end
			want = expected_lines.pop_front();
			compare_field("line_kind", want.line_kind, got.line_kind);
			compare_field("major_id", want.major_id, got.major_id);
			compare_field("minor_id", want.minor_id, got.minor_id);
			compare_field("tx_power", want.tx_power, got.tx_power);
			compare_field("rssi_dbm", want.rssi_dbm, got.rssi_dbm);
			compare_field("devices_seen", want.devices_seen, got.devices_seen);
			compare_field("beacons_seen", want.beacons_seen, got.beacons_seen);
		endfunction

		function void flag_leftovers();
			if (expected_lines.size() != 0) begin
				$error("%0d expected results never arrived", expected_lines.size());
				failures++;
			end
		endfunction
	endclass

endpackage

/* tb/tb_ble_beacon_scan_line_parser.sv */
// ----------------------------------------------------------------------------
// Scan-reply line parser testbench
// Feeds directed and random scan-reply lines under several register settings,
// with random idling on both channels, and checks every result transaction.
// ----------------------------------------------------------------------------
module tb_ble_beacon_scan_line_parser;
	import bsp_pkg::*;
	import scan_reply_sb_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int DRAIN_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int STEADY_LINES = 12;

	logic               clk      = 1'b0;
	logic               arst_n   = 1'b0;
	logic               psel     = 1'b0;
	logic               penable  = 1'b0;
	logic               pwrite   = 1'b0;
	logic [ADDR_W-1:0]  paddr    = '0;
	logic [DATA_W-1:0]  pwdata   = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         rx_byte  = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         line_kind;
	logic [15:0]        major_id;
	logic [15:0]        minor_id;
	logic signed [7:0]  tx_power;
	logic signed [15:0] rssi_dbm;
	logic [15:0]        devices_seen;
	logic [15:0]        beacons_seen;

	scan_reply_scoreboard line_checker = new();
	logic [7:0]           line_buf[$];
	int                   bytes_sent = 0;
	bit                   steady     = 1'b0;
	bit                   hold_req   = 1'b0;
	bit                   hold_done  = 1'b0;

	ble_beacon_scan_line_parser u_dut (.*);

	always #HALF_PERIOD clk = ~clk;

	function automatic int pick_gap();
		if ($urandom_range(0, 9) == 0) return $urandom_range(12, 40);
		return $urandom_range(1, 3);
	endfunction

	// Outputs settle after each rising edge, so the falling edge sees exactly
	// what the next rising edge will take.
	always @(negedge clk) begin
		res_t got;
		if (arst_n) begin
			if (in_valid && in_ready) line_checker.take_byte(rx_byte);
			if (out_valid && out_ready) begin
				got.line_kind    = line_kind_t'(line_kind);
				got.major_id     = major_id;
				got.minor_id     = minor_id;
				got.tx_power     = tx_power;
				got.rssi_dbm     = rssi_dbm;
				got.devices_seen = devices_seen;
				got.beacons_seen = beacons_seen;
				line_checker.check_result(got);
			end
		end
	end

	initial begin : receiver
		forever begin
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat (pick_gap()) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		bit taken;
		if (!steady && $urandom_range(0, 2) == 0) begin
			in_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i]) send_byte(line_buf[i]);
		send_byte(CHAR_CR);
		line_buf.delete();
	endtask

	function automatic void put_text(string s);
		for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
	endfunction

	function automatic void put_random(int n, logic [7:0] lo, logic [7:0] hi);
		repeat (n) line_buf.push_back(8'($urandom_range(lo, hi)));
	endfunction

	function automatic void put_hex(logic [63:0] v, int digits, bit mixed_case);
		logic [7:0] ch;
		for (int i = digits - 1; i >= 0; i--) begin
			ch = hex_char(v[4*i +: 4]);
			if (mixed_case && ch >= "A" && $urandom_range(0, 1) == 1) ch = ch + 8'h20;
			line_buf.push_back(ch);
		end
	endfunction

	// Positions 0 to 49 of a discovery line that matches the current setting.
	function automatic void put_beacon_head();
		put_text("OK+DISC:");
		put_hex({32'b0, line_checker.company}, 8, 1'b0);
		put_text(":");
		put_hex(line_checker.uuid_hi, 16, 1'b0);
		put_hex(line_checker.uuid_lo, 16, 1'b0);
		put_text(":");
	endfunction

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (line_checker.expected_lines.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input int idx, input bit wr, input logic [63:0] wdata,
		output logic [63:0] rdata);
		bit done;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= ADDR_W'(8 * idx);
		pwdata  <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do begin
			@(negedge clk);
			done  = pready;
			rdata = prdata;
			@(posedge clk);
		end while (!done);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_register(input int idx, input logic [63:0] value);
		logic [63:0] readback;
		logic [63:0] mask;
		apb_access(idx, 1'b1, value, readback);
		line_checker.write_register(idx, value);
		apb_access(idx, 1'b0, '0, readback);
		mask = (idx == REG_COMPANY) ? 64'hFFFF_FFFF : '1;
		if ((readback & mask) !== (value & mask)) begin
			$error("register %0d: expected %h, got %h", idx, value & mask, readback & mask);
			line_checker.failures++;
		end
	endtask

	task automatic apply_config(input logic [31:0] company, input logic [63:0] hi,
		input logic [63:0] lo);
		wait_idle();
		set_register(REG_COMPANY, {32'b0, company});
		set_register(REG_UUID_HI, hi);
		set_register(REG_UUID_LO, lo);
	endtask

	// Mostly well-formed beacon lines with random content and occasional damage,
	// mixed with other discovery lines, scan markers and raw noise.
	task automatic run_random(input int byte_goal);
		int first;
		int pick;
		int pos;
		int digits;
		first = bytes_sent;
		while (bytes_sent - first < byte_goal) begin
			pick = $urandom_range(0, 19);
			if (pick < 10) begin
				put_beacon_head();
				put_hex({$urandom, $urandom}, 10, 1'b1);
				if ($urandom_range(0, 4) == 0)
					line_buf[POS_MAJOR + $urandom_range(0, 9)] = 8'($urandom_range(8'h47, 8'h7E));
				put_text(":");
				put_hex({$urandom, $urandom}, 12, 1'b0);
				put_text(":");
				if ($urandom_range(0, 3) == 0) begin
					repeat ($urandom_range(1, 3)) begin
						case ($urandom_range(0, 3))
							0: line_buf.push_back(8'h20);
							1: line_buf.push_back(8'h09);
							2: line_buf.push_back(8'h0B);
							default: line_buf.push_back(8'h0C);
						endcase
					end
				end
				case ($urandom_range(0, 2))
					1: put_text("+");
					2: put_text("-");
					default: ;
				endcase
				pos = $urandom_range(0, 9);
				digits = (pos < 8) ? $urandom_range(1, 3) : ((pos == 8) ? $urandom_range(4, 7) : 0);
				put_random(digits, "0", "9");
				if ($urandom_range(0, 3) == 0) put_random(1, 8'h00, 8'hFF);
				if ($urandom_range(0, 9) < 3) begin
					case ($urandom_range(0, 4))
						0: line_buf[$urandom_range(0, line_buf.size() - 1)] =
							8'($urandom_range(0, 255));
						1: begin
							pos = $urandom_range(0, line_buf.size());
							while (line_buf.size() > pos) void'(line_buf.pop_back());
						end
						2: put_random($urandom_range(20, 110), 8'h20, 8'h7E);
						3: line_buf.insert($urandom_range(0, line_buf.size()), CHAR_LF);
						default: begin
							// A lowercase letter in the prefix or the UUID must not match.
							pos = $urandom_range(POS_COMPANY, POS_UUID_END - 1);
							line_buf[pos] = line_buf[pos] | 8'h20;
						end
					endcase
				end
			end else if (pick < 13) begin
				put_text("OK+DISC:");
				put_random($urandom_range(0, 60), 8'h20, 8'h7E);
			end else if (pick < 15) begin
				put_text("OK+DISIS");
				put_random($urandom_range(0, 10), 8'h20, 8'h7E);
			end else if (pick < 17) begin
				put_text("OK+DISCE");
				put_random($urandom_range(0, 10), 8'h20, 8'h7E);
			end else begin
				put_random($urandom_range(0, 140), 8'h00, 8'hFF);
			end
			send_line();
		end
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed lines under the reset setting.
		put_beacon_head();
		put_text("1234ABCDC5:0123456789AB:-059");
		send_line();
		put_beacon_head();
		put_text("ffff000080:0123456789AB:+32767");
		send_line();
		put_beacon_head();
		put_text("abCD12ef7F:0123456789AB: \t");
		line_buf.push_back(8'h0B);
		line_buf.push_back(8'h0C);
		put_text("-99999");
		send_line();
		put_beacon_head();
		put_text("1G2300z07F:0123456789AB:99999x12");
		send_line();
		put_beacon_head();
		put_text("A:");
		send_line();
		put_beacon_head();
		send_line();
		// The shortest line that can still be a beacon, and one byte shorter.
		put_beacon_head();
		void'(line_buf.pop_back());
		send_line();
		put_beacon_head();
		void'(line_buf.pop_back());
		void'(line_buf.pop_back());
		send_line();
		// The UUID character at this position is an uppercase B by default.
		put_beacon_head();
		line_buf[22] = "b";
		put_text("1234ABCDC5");
		send_line();
		put_text("OK+DISC:");
		send_line();
		put_text("OK+DISIS");
		send_line();
		put_text("OK+DISCE");
		send_line();
		send_line();
		put_text("OK+DIS");
		send_line();
		put_text("OK+DISC");
		line_buf.push_back(8'h00);
		send_line();
		put_beacon_head();
		put_text("1234ABCDC5:0123456789AB:");
		line_buf.push_back(8'h00);
		put_text("-5");
		send_line();
		put_beacon_head();
		put_text("00FF00FF01:0123456789AB:-");
		put_random(150, "9", "9");
		send_line();
		put_random(200, 8'hFF, 8'hFF);
		send_line();
		line_buf.push_back(CHAR_LF);
		put_beacon_head();
		line_buf.insert(30, CHAR_LF);
		put_text("BEEF0102FE:0123456789AB:12");
		send_line();
		send_byte(CHAR_LF);

		// Short lines while the receiver holds off, so the result path fills up.
		hold_req = 1'b1;
		repeat (16) begin
			put_text("OK+DISC:");
			send_line();
		end

		run_random(120);
		apply_config($urandom, {$urandom, $urandom}, {$urandom, $urandom});
		run_random(80);
		apply_config('0, '0, '0);
		run_random(60);
		apply_config('1, '1, '1);
		run_random(60);
		apply_config($urandom, {$urandom, $urandom}, {$urandom, $urandom});

		// Back-to-back discovery lines with no idling on either side.
		steady = 1'b1;
		put_text("OK+DISIS");
		send_line();
		repeat (STEADY_LINES) begin
			put_text("OK+DISC:");
			send_line();
		end
		put_beacon_head();
		send_line();
		put_text("OK+DISCE");
		send_line();
		steady = 1'b0;

		run_random(60);
		wait_idle();
		line_checker.flag_leftovers();
		if (line_checker.failures == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#(64'd8 * 64'd4_000_000);
		$display("FAIL");
		$finish;
	end

endmodule
